FILE: sv/bli_pkg.sv
`timescale 1ns / 1ps
package bli_pkg;
  localparam int unsigned TimeW = 16;
  localparam int unsigned PosW = 18;
  localparam int unsigned FracW = 17;
  localparam int unsigned StatW = 2;
  localparam int unsigned CfgW = 18;
  localparam int unsigned CfgIdxW = 2;

  typedef logic [CfgIdxW-1:0] cfg_idx_t;
  localparam cfg_idx_t CfgDuration = 2'd0;
  localparam cfg_idx_t CfgStartPos = 2'd1;
  localparam cfg_idx_t CfgEndPos = 2'd2;

  typedef logic [StatW-1:0] status_t;
  localparam status_t StQuery = 2'd0;
  localparam status_t StStored = 2'd1;
  localparam status_t StDup = 2'd2;
  localparam status_t StFull = 2'd3;

  localparam logic signed [PosW-1:0] PosOne = 18'sd65536;

  typedef struct packed {
    logic [TimeW-1:0] time_ms;
    logic [PosW-1:0] pos;
    logic valid;
  } entry_t;

  // Control broadcast to every cell in the chain.
  typedef struct packed {
    logic rot;
    logic ins_en;
    logic [TimeW-1:0] key;
  } cell_ctrl_t;
endpackage

FILE: sv/bli_if.sv
`timescale 1ns / 1ps
interface bli_in_if;
  logic valid;
  logic ready;
  logic kind;
  logic [15:0] time_ms;
  logic [16:0] point_fraction;
  logic signed [17:0] point_position;
  modport source(output valid, kind, time_ms, point_fraction, point_position, input ready);
  modport sink(input valid, kind, time_ms, point_fraction, point_position, output ready);
endinterface

interface bli_out_if;
  logic valid;
  logic ready;
  logic signed [17:0] position;
  logic [1:0] status;
  modport source(output valid, position, status, input ready);
  modport sink(input valid, position, status, output ready);
endinterface

FILE: sv/breakpoint_linear_interpolator.sv
`timescale 1ns / 1ps
// Breakpoint linear interpolator. Maps a time in milliseconds to a signed
// Q2.16 position by straight-line interpolation between the start point at
// time zero, the end point at duration_ms and up to MAX_POINTS stored
// breakpoints kept sorted by time in a row of cells. An add item computes
// its time as (duration_ms * fraction) >> 16, checks for duplicates while
// the row makes one full rotation and then inserts the new entry by
// shifting the later entries one place right. A query sweeps the row the
// same way; a query that lands between breakpoints then runs a 32 step
// restoring divider and a multiply and shift, while queries at zero, at
// the end, past the end or on a stored breakpoint skip both. One item is
// worked on at a time: the input is ready again only in the cycle after
// the result transfer.
module breakpoint_linear_interpolator #(
  parameter int unsigned MAX_POINTS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [bli_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [bli_pkg::CfgW-1:0] cfg_data_i,
  bli_in_if.sink      in_i,
  bli_out_if.source   out_o
);
  import bli_pkg::*;
  localparam int unsigned CntW = $clog2(MAX_POINTS + 1);
  localparam int unsigned IdxW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

  typedef enum logic [6:0] {
    SIdle  = 7'b0000001,
    SAddMul = 7'b0000010,
    SAddScan = 7'b0000100,
    SQScan = 7'b0001000,
    SQDiv  = 7'b0010000,
    SQMul  = 7'b0100000,
    SOut   = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  logic [TimeW-1:0] dur_q;
  logic signed [PosW-1:0] spos_q, epos_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dur_q <= 16'd1000;
      spos_q <= 18'sd0;
      epos_q <= 18'sd65536;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgDuration: dur_q <= cfg_data_i[TimeW-1:0];
        CfgStartPos: spos_q <= cfg_data_i;
        CfgEndPos: epos_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Item registers.
  logic [TimeW-1:0] t_q;
  logic signed [PosW-1:0] ppos_q;
  logic [16:0] frac_q;
  logic [CntW-1:0] count_q;
  logic [IdxW:0] scan_q;
  logic dup_q, hit_q;
  logic [TimeW-1:0] t0_q, t1_q;
  logic signed [PosW-1:0] p0_q, p1_q, hitpos_q;
  logic signed [PosW-1:0] res_pos_q;
  status_t res_st_q;
  logic out_valid_q;
  logic [16:0] qfrac_q;
  logic signed [36:0] prod_q;

  // Cell row.
  entry_t ent [MAX_POINTS];
  cell_ctrl_t ctrl;
  entry_t ins;

  // The rotate mode feeds the tail into the head for the sweep; a full
  // rotation through all MAX_POINTS cells restores the order.
  assign ins.time_ms = t_q;
  assign ins.pos = ppos_q;
  assign ins.valid = 1'b1;

  for (genvar g = 0; g < MAX_POINTS; g++) begin : g_cell
    entry_t prev_e;
    if (g == 0) begin : g_head
      assign prev_e = ent[MAX_POINTS-1];
    end else begin : g_body
      assign prev_e = ent[g-1];
    end
    bli_cell u_cell (
      .clk_i(clk_i), .rst_ni(rst_ni), .head_i((g == 0) ? 1'b1 : 1'b0), .ctrl_i(ctrl),
      .prev_i(prev_e), .ins_i(ins), .ent_o(ent[g])
    );
  end

  // The sweep reads the tail; rotation moves all cells, valid flag included,
  // so a full pass through all MAX_POINTS cells shows each entry once.
  entry_t tail;
  assign tail = ent[MAX_POINTS-1];

  logic div_start, div_done;
  logic [16:0] div_quo;
  bli_divider u_div (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(div_start),
    .num_i(t_q - t0_q), .den_i(t1_q - t0_q), .done_o(div_done), .quo_o(div_quo)
  );

  logic [32:0] add_prod;
  assign add_prod = dur_q * frac_q;

  logic signed [PosW:0] pdiff;
  assign pdiff = {p1_q[PosW-1], p1_q} - {p0_q[PosW-1], p0_q};

  logic in_fire;
  assign in_i.ready = (state_q == SIdle) && !out_valid_q;
  assign in_fire = in_i.valid && in_i.ready;

  always_comb begin
    state_d = state_q;
    ctrl.rot = 1'b0;
    ctrl.ins_en = 1'b0;
    ctrl.key = t_q;
    div_start = 1'b0;
    case (state_q)
      SIdle: if (in_fire) state_d = in_i.kind ? SAddMul : SQScan;
      SAddMul: state_d = SAddScan;
      SAddScan: begin
        if (scan_q == (IdxW+1)'(MAX_POINTS)) begin
          if (!(t_q == '0 || t_q == dur_q || dup_q) &&
              count_q < CntW'(MAX_POINTS)) ctrl.ins_en = 1'b1;
          state_d = SOut;
        end else begin
          ctrl.rot = 1'b1;
        end
      end
      SQScan: begin
        if (scan_q == (IdxW+1)'(MAX_POINTS)) begin
          if (t_q > dur_q || t_q == '0 || t_q == dur_q || hit_q) state_d = SOut;
          else begin
            div_start = 1'b1;
            state_d = SQDiv;
          end
        end else begin
          ctrl.rot = 1'b1;
        end
      end
      SQDiv: if (div_done) state_d = SQMul;
      SQMul: state_d = SOut;
      SOut: state_d = SIdle;
      default: state_d = SIdle;
    endcase
  end

  logic slot_valid;
  assign slot_valid = tail.valid;

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      t_q <= in_i.time_ms;
      ppos_q <= in_i.point_position;
      frac_q <= (in_i.point_fraction > 17'd65536) ? 17'd65536 : in_i.point_fraction;
      t0_q <= '0;
      t1_q <= dur_q;
      p0_q <= spos_q;
      p1_q <= epos_q;
    end
    if (state_q == SAddMul) t_q <= add_prod[31:16];
    if (state_q == SQScan && scan_q != (IdxW+1)'(MAX_POINTS) && slot_valid &&
        tail.time_ms != '0 && tail.time_ms < dur_q) begin
      if (tail.time_ms == t_q) hitpos_q <= tail.pos;
      else if (tail.time_ms < t_q && tail.time_ms >= t0_q) begin
        t0_q <= tail.time_ms;
        p0_q <= tail.pos;
      end else if (tail.time_ms > t_q && tail.time_ms < t1_q) begin
        t1_q <= tail.time_ms;
        p1_q <= tail.pos;
      end
    end
    if (div_done) qfrac_q <= div_quo;
    if (state_q == SQMul) prod_q <= pdiff * $signed({1'b0, qfrac_q});
  end

  logic signed [PosW-1:0] interp_pos;
  assign interp_pos = p0_q + PosW'(prod_q >>> 16);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      count_q <= '0;
      scan_q <= '0;
      dup_q <= 1'b0;
      hit_q <= 1'b0;
      out_valid_q <= 1'b0;
      res_pos_q <= '0;
      res_st_q <= StQuery;
    end else begin
      state_q <= state_d;
      if (out_valid_q && out_o.ready) out_valid_q <= 1'b0;
      if (in_fire) begin
        scan_q <= '0;
        dup_q <= 1'b0;
        hit_q <= 1'b0;
      end
      if ((state_q == SAddScan || state_q == SQScan) &&
          scan_q != (IdxW+1)'(MAX_POINTS)) begin
        scan_q <= scan_q + 1'b1;
        if (tail.valid && tail.time_ms == t_q) dup_q <= 1'b1;
        if (state_q == SQScan && tail.valid && tail.time_ms != '0 &&
            tail.time_ms < dur_q && tail.time_ms == t_q) hit_q <= 1'b1;
      end
      if (state_q == SAddScan && scan_q == (IdxW+1)'(MAX_POINTS)) begin
        res_pos_q <= '0;
        if (t_q == '0 || t_q == dur_q || dup_q) res_st_q <= StDup;
        else if (count_q >= CntW'(MAX_POINTS)) res_st_q <= StFull;
        else begin
          res_st_q <= StStored;
          count_q <= count_q + 1'b1;
        end
      end
      if (state_q == SQScan && scan_q == (IdxW+1)'(MAX_POINTS)) begin
        res_st_q <= StQuery;
        if (t_q > dur_q) res_pos_q <= PosOne;
        else if (t_q == '0) res_pos_q <= spos_q;
        else if (t_q == dur_q) res_pos_q <= epos_q;
        else if (hit_q) res_pos_q <= hitpos_q;
      end
      if (state_q == SQMul) res_st_q <= StQuery;
      if (state_q == SOut) begin
        out_valid_q <= 1'b1;
        if (res_st_q == StQuery && !(t_q > dur_q || t_q == '0 || t_q == dur_q || hit_q))
          res_pos_q <= interp_pos;
      end
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.position = res_pos_q;
  assign out_o.status = res_st_q;
endmodule

FILE: sv/bli_cell.sv
`timescale 1ns / 1ps
module bli_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                head_i,
  input  bli_pkg::cell_ctrl_t ctrl_i,
  input  bli_pkg::entry_t     prev_i,
  input  bli_pkg::entry_t     ins_i,
  output bli_pkg::entry_t     ent_o
);
  import bli_pkg::*;
  entry_t ent_q, ent_d;
  logic prev_gt, self_gt, first_free;

  // Insertion into a sorted row: a cell takes its left neighbor if that one
  // is above the key, else the new entry if it is itself above the key or
  // is the first empty cell. Rotation moves every cell one place right.
  assign prev_gt = !head_i && prev_i.valid && (prev_i.time_ms > ctrl_i.key);
  assign self_gt = ent_q.valid && (ent_q.time_ms > ctrl_i.key);
  assign first_free = !ent_q.valid && (head_i || prev_i.valid);

  always_comb begin
    ent_d = ent_q;
    if (ctrl_i.rot) begin
      ent_d = prev_i;
    end else if (ctrl_i.ins_en) begin
      if (prev_gt) ent_d = prev_i;
      else if (self_gt || first_free) ent_d = ins_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_q <= '0;
    end else begin
      ent_q <= ent_d;
    end
  end

  assign ent_o = ent_q;
endmodule

FILE: sv/bli_divider.sv
`timescale 1ns / 1ps
module bli_divider (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [15:0] num_i,
  input  logic [15:0] den_i,
  output logic        done_o,
  output logic [16:0] quo_o
);
  import bli_pkg::*;
  // Restoring division of num<<16 by den, one quotient bit a cycle.
  logic [31:0] num_q, num_d;
  logic [16:0] rem_q, rem_d;
  logic [15:0] den_q;
  logic [16:0] quo_q, quo_d;
  logic [5:0] cnt_q;
  logic busy_q;
  logic [16:0] trial;

  always_comb begin
    trial = {rem_q[15:0], num_q[31]};
    num_d = {num_q[30:0], 1'b0};
    if (trial >= {1'b0, den_q}) begin
      rem_d = trial - {1'b0, den_q};
      quo_d = {quo_q[15:0], 1'b1};
    end else begin
      rem_d = trial;
      quo_d = {quo_q[15:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= {num_i, 16'd0};
      den_q <= den_i;
      rem_q <= '0;
      quo_q <= '0;
    end else if (busy_q) begin
      num_q <= num_d;
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q <= 6'd32;
    end else if (busy_q) begin
      cnt_q <= cnt_q - 6'd1;
      if (cnt_q == 6'd1) busy_q <= 1'b0;
    end
  end

  assign done_o = busy_q && (cnt_q == 6'd1);
  assign quo_o = quo_d;
endmodule

FILE: verif/tb_ifs.sv
`timescale 1ns / 1ps
// The block's channel interfaces live in the RTL folder; this file holds the
// simple configuration bundle that the bench uses to drive register writes.
interface tb_cfg_if;
  logic we;
  logic [1:0] index;
  logic [17:0] data;
endinterface

FILE: verif/tb.sv
`timescale 1ns / 1ps
// Bench for the breakpoint linear interpolator. An initial block builds
// phases of add and query items into a pending queue; a clocked driver
// presents them on the input channel and a clocked monitor compares every
// result transfer with the oldest prediction. Register writes happen only
// between phases, once the block has drained.
module tb;
  import bli_pkg::*;

  localparam int unsigned MaxPts = 16;
  localparam int unsigned WatchLimit = 20000;

  typedef struct packed {
    logic kind;
    logic [TimeW-1:0] time_ms;
    logic [FracW-1:0] point_fraction;
    logic signed [PosW-1:0] point_position;
  } req_t;

  typedef struct packed {
    logic signed [PosW-1:0] position;
    status_t status;
  } rsp_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  tb_cfg_if cfg_ch();
  bli_in_if in_ch();
  bli_out_if out_ch();

  breakpoint_linear_interpolator #(.MAX_POINTS(MaxPts)) i_dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_ch.we),
    .cfg_index_i(cfg_ch.index), .cfg_data_i(cfg_ch.data),
    .in_i(in_ch.sink), .out_o(out_ch.source)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Model state of the block.
  int unsigned dur_ms;
  int start_pos, end_pos;
  int unsigned pt_time[MaxPts];
  int pt_pos[MaxPts];
  int unsigned pt_count;

  req_t pending_items[$];
  rsp_t expected_results[$];
  int unsigned send_idle_pct, recv_stall_pct;
  int errors = 0;
  int unsigned quiet_cycles = 0;

  function automatic int lerp_position(int unsigned t, int unsigned t0, int p0,
                                       int unsigned t1, int p1);
    longint unsigned frac;
    longint prod, q;
    frac = (longint'(t - t0) << 16) / longint'(t1 - t0);
    prod = longint'(p1 - p0) * longint'(frac);
    q = prod >>> 16;  // arithmetic shift rounds toward minus infinity
    return p0 + int'(q);
  endfunction

  function automatic int position_at(int unsigned t);
    int unsigned t0, t1, bt;
    int p0, p1;
    t0 = 0; t1 = dur_ms; p0 = start_pos; p1 = end_pos;
    if (t > dur_ms) return int'(PosOne);
    if (t == 0) return start_pos;
    if (t == dur_ms) return end_pos;
    for (int i = 0; i < pt_count; i++) begin
      bt = pt_time[i];
      if (bt == 0 || bt >= dur_ms) continue;
      if (bt == t) return pt_pos[i];
      if (bt < t && bt >= t0) begin
        t0 = bt; p0 = pt_pos[i];
      end else if (bt > t && bt < t1) begin
        t1 = bt; p1 = pt_pos[i];
      end
    end
    return lerp_position(t, t0, p0, t1, p1);
  endfunction

  function automatic status_t store_point(int unsigned fraction, int pos);
    int unsigned f, t, k;
    f = (fraction > 65536) ? 65536 : fraction;
    t = int'((longint'(dur_ms) * f) >> 16);
    if (t == 0 || t == dur_ms) return StDup;
    for (int i = 0; i < pt_count; i++)
      if (pt_time[i] == t) return StDup;
    if (pt_count >= MaxPts) return StFull;
    k = pt_count;
    while (k > 0 && pt_time[k-1] > t) begin
      pt_time[k] = pt_time[k-1];
      pt_pos[k] = pt_pos[k-1];
      k--;
    end
    pt_time[k] = t;
    pt_pos[k] = pos;
    pt_count++;
    return StStored;
  endfunction

  function automatic rsp_t predict_result(req_t r);
    rsp_t o;
    if (r.kind == 1'b0) begin
      o.position = PosW'(position_at(r.time_ms));
      o.status = StQuery;
    end else begin
      o.status = store_point(r.point_fraction, int'(r.point_position));
      o.position = '0;
    end
    return o;
  endfunction

  // Driver: one item per transfer, valid held until accepted.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
      in_ch.kind <= 1'b0;
      in_ch.time_ms <= '0;
      in_ch.point_fraction <= '0;
      in_ch.point_position <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        expected_results.push_back(predict_result({in_ch.kind, in_ch.time_ms,
            in_ch.point_fraction, in_ch.point_position}));
        void'(pending_items.pop_front());
      end
      // Decide on the queue as it stands after this transfer.
      if ((in_ch.valid && !in_ch.ready) ||
          (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct)) begin
        if (!(in_ch.valid && !in_ch.ready)) begin
          in_ch.valid <= 1'b1;
          {in_ch.kind, in_ch.time_ms, in_ch.point_fraction, in_ch.point_position}
              <= pending_items[0];
        end
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Monitor: checks each result transfer and drives the receiver stall.
  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t want;
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result pos=%0d status=%0d", $time,
                   out_ch.position, out_ch.status);
          errors++;
        end else begin
          want = expected_results.pop_front();
          if (want.position !== out_ch.position || want.status !== out_ch.status) begin
            $display("%0t: mismatch expected pos=%0d status=%0d actual pos=%0d status=%0d",
                     $time, want.position, want.status, out_ch.position, out_ch.status);
            errors++;
          end
        end
      end
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_ni)
      quiet_cycles <= 0;
    else if (pending_items.size() > 0 || expected_results.size() > 0) begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WatchLimit) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  task automatic write_reg(cfg_idx_t idx, logic [CfgW-1:0] value);
    @(posedge clk_i);
    cfg_ch.we <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= value;
    @(posedge clk_i);
    cfg_ch.we <= 1'b0;
    case (idx)
      CfgDuration: dur_ms = value[TimeW-1:0];
      CfgStartPos: start_pos = int'($signed(value));
      default: end_pos = int'($signed(value));
    endcase
  endtask

  task automatic drain();
    while (pending_items.size() != 0 || expected_results.size() != 0 || in_ch.valid)
      @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  function automatic req_t add_item(int unsigned fr, int pos);
    req_t r;
    r.kind = 1'b1; r.time_ms = TimeW'($urandom()); r.point_fraction = FracW'(fr);
    r.point_position = PosW'(pos);
    return r;
  endfunction

  function automatic req_t query_item(int unsigned t);
    req_t r;
    r.kind = 1'b0; r.time_ms = TimeW'(t); r.point_fraction = FracW'($urandom());
    r.point_position = PosW'($urandom());
    return r;
  endfunction

  function automatic int rand_pos();
    return $urandom_range(262143) - 131072;
  endfunction

  // A random mix, mostly queries inside the duration with some adds, plus noise.
  task automatic random_phase(int unsigned n);
    int unsigned sel;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(99);
      if (sel < 22)
        pending_items.push_back(add_item($urandom_range(65536), rand_pos()));
      else if (sel < 25)
        pending_items.push_back(add_item($urandom_range(131071), rand_pos()));
      else if (sel < 90)
        pending_items.push_back(query_item($urandom_range(dur_ms)));
      else
        pending_items.push_back(query_item($urandom_range(65535)));
    end
  endtask

  initial begin
    cfg_ch.we = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    dur_ms = 1000; start_pos = 0; end_pos = 65536; pt_count = 0;
    send_idle_pct = 0; recv_stall_pct = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part on reset settings: ends, past the end, fractions above
    // one, duplicates, then filling the store until it reports full.
    pending_items.push_back(query_item(0));
    pending_items.push_back(query_item(1000));
    pending_items.push_back(query_item(1001));
    pending_items.push_back(query_item(65535));
    pending_items.push_back(query_item(500));
    pending_items.push_back(add_item(0, 5));
    pending_items.push_back(add_item(65536, 5));
    pending_items.push_back(add_item(131071, 5));
    pending_items.push_back(add_item(32768, -131072));
    pending_items.push_back(add_item(32768, 131071));
    for (int i = 1; i <= 16; i++)
      pending_items.push_back(add_item(i * 3000, (i % 2) ? 131071 : -131072));
    pending_items.push_back(query_item(500));
    pending_items.push_back(query_item(1));
    pending_items.push_back(query_item(999));
    drain();

    // Extreme settings; shorter duration leaves stored points out of range.
    write_reg(CfgDuration, 18'd300);
    write_reg(CfgStartPos, 18'h20000);
    write_reg(CfgEndPos, 18'h1FFFF);
    random_phase(100);
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      // A fresh store only comes from reset, so vary settings instead.
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 88; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 88; end
        3: begin send_idle_pct = 30; recv_stall_pct = 30; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      write_reg(CfgDuration, (ph == 4) ? 18'd65535 : (ph == 1) ? 18'd1 :
                CfgW'($urandom_range(65535, 2)));
      write_reg(CfgStartPos, CfgW'(rand_pos()));
      write_reg(CfgEndPos, CfgW'(rand_pos()));
      random_phase(300);
      drain();
    end

    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
